// ===== rtl/adap_pkg.sv =====
// Shared constants and tables for the air-data angles and pressure block.
// Used by adap_cordic and air_data_angles_and_pressure_top; no dependencies.
package adap_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = 5;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [17:0] ALPHA_MAX   = 18'sd25736;
  localparam logic signed [17:0] BETA_MAX    = 18'sd12868;
  localparam logic [32:0]        RATE_MAX    = 33'd16384;

  // Truncated atan(2^-i) in radians Q30.
  function automatic logic [31:0] atan_q30(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/adap_cordic.sv =====
// Iterative CORDIC vectoring unit: atan2(yv, xv) rounded to radians Q13.
// Depends on adap_pkg for the angle table and the iteration count.
module adap_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [21:0]  yv,
  input  logic signed [21:0]  xv,
  output logic                done,
  output logic signed [17:0]  angle
);

  logic                              busy_r;
  logic                              done_r;
  logic                              zero_r;
  logic [adap_pkg::CNT_W-1:0]        cnt_r;
  logic signed [48:0]                x_r;
  logic signed [48:0]                y_r;
  logic signed [33:0]                z_r;
  logic signed [48:0]                xs;
  logic signed [48:0]                ys;
  logic signed [48:0]                dx;
  logic signed [48:0]                dy;
  logic signed [33:0]                ang;
  logic signed [34:0]                zround;

  assign xs  = 49'(xv) <<< 24;
  assign ys  = 49'(yv) <<< 24;
  assign dx  = y_r >>> cnt_r;
  assign dy  = x_r >>> cnt_r;
  assign ang = $signed({2'b00, adap_pkg::atan_q30(cnt_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        zero_r <= (xv == 22'sd0) && (yv == 22'sd0);
        // Bring a vector in the left half plane into the right half first.
        if (xs < 0) begin
          if (ys >= 0) begin
            x_r <= ys;
            y_r <= -xs;
            z_r <= adap_pkg::HALF_PI_Q30;
          end else begin
            x_r <= -ys;
            y_r <= xs;
            z_r <= -adap_pkg::HALF_PI_Q30;
          end
        end else begin
          x_r <= xs;
          y_r <= ys;
          z_r <= '0;
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - ang;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == adap_pkg::CNT_W'(adap_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign zround = 35'(z_r) + 35'sd65536;
  assign angle  = zero_r ? 18'sd0 : zround[34:17];
  assign done   = done_r;

endmodule

// ===== rtl/air_data_angles_and_pressure_top.sv =====
// Air-data block: airspeed, angle of attack, alpha rate, sideslip, dynamic pressure.
// A request runs through 5 multiplier passes and a sum, two 21-step square roots with
// S_RT1_END and S_RT2_LD around them, two CORDIC runs of CORDIC_STEPS steps each and a
// 33-step divider for the alpha rate, which is skipped when step_time is zero.
// A new request is taken only in S_IDLE, once the last one is through; a result still unread stalls the sequencer.
// Synchronous active-low reset clears the sequencer, output valid, alpha reference and held rate.
module air_data_angles_and_pressure_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_x, vel_y, vel_z, wind_x, wind_y, wind_z, air_density, step_time, pad
  input  logic [151:0] in_tdata,
  input  logic         in_tlast,   // end_of_step
  output logic         out_tvalid,
  input  logic         out_tready,
  // airspeed, attack_angle, attack_rate, sideslip_angle, dynamic_pressure, pad
  output logic [95:0]  out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_SUM, S_QLO, S_QHI, S_RT1, S_RT1_END, S_RT2_LD,
    S_RT2, S_AL_GO, S_AL_WAIT, S_DIV_LD, S_DIV, S_BE_GO, S_BE_WAIT, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic signed [21:0] ax_r, ay_r, az_r;
  logic [14:0]        rho_r;
  logic [15:0]        h_r;
  logic               store_r;
  logic [40:0]        sx_r;
  logic [41:0]        sy_r;
  logic [41:0]        syz_r;
  logic [41:0]        s_r;
  logic [35:0]        qlo_r;
  logic [23:0]        qbar_r;
  logic [19:0]        spd_r;
  logic [21:0]        side_r;
  logic signed [15:0] alpha_r;
  logic signed [14:0] beta_r;
  logic signed [15:0] ref_alpha_r;
  logic signed [15:0] held_rate_r;
  logic               neg_r;

  // Shared square root unit.
  logic [41:0] sq_v_r;
  logic [42:0] sq_r_r;
  logic [41:0] sq_b_r;
  logic [42:0] sq_t;

  // Divider for the alpha rate.
  logic [32:0] quo_r;
  logic [15:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [16:0] dsh;

  // Shared multiplier.
  logic [20:0] mul_a;
  logic [20:0] mul_b;
  logic [41:0] prod;
  logic [57:0] qsum;
  logic [26:0] qsh;

  logic               cs_start;
  logic signed [21:0] cs_y, cs_x;
  logic               cs_done;
  logic signed [17:0] cs_angle;
  logic signed [17:0] alpha_c;
  logic signed [17:0] beta_c;
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [32:0]        rate_mag;
  logic signed [15:0] rate_s;

  logic out_valid_r;
  logic [95:0] out_data_r;

  function automatic logic [20:0] mag(input logic signed [21:0] v);
    logic signed [21:0] n;
    n = -v;
    return v[21] ? n[20:0] : v[20:0];
  endfunction

  always_comb begin
    mul_a = mag(ax_r);
    mul_b = mag(ax_r);
    case (state_r)
      S_SQY: begin mul_a = mag(ay_r); mul_b = mag(ay_r); end
      S_SQZ: begin mul_a = mag(az_r); mul_b = mag(az_r); end
      // The pressure product is formed from the low and the high half of |a|^2.
      S_QLO: begin mul_a = s_r[20:0]; mul_b = {6'd0, rho_r}; end
      S_QHI: begin mul_a = s_r[41:21]; mul_b = {6'd0, rho_r}; end
      default: ;
    endcase
  end

  assign prod = 42'(mul_a) * 42'(mul_b);
  assign qsum = ({22'd0, prod[35:0]} << 21) + 58'(qlo_r) + 58'd1073741824;
  assign qsh  = qsum[57:31];
  assign sq_t = 43'(sq_r_r) + 43'(sq_b_r);
  assign dsh  = {rem_r, quo_r[32]};

  assign cs_start = (state_r == S_AL_GO) || (state_r == S_BE_GO);
  assign cs_y     = (state_r == S_AL_GO) ? az_r : ax_r;
  assign cs_x     = (state_r == S_AL_GO) ? ay_r : side_r;

  adap_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .yv    (cs_y),
    .xv    (cs_x),
    .done  (cs_done),
    .angle (cs_angle)
  );

  always_comb begin
    alpha_c = cs_angle;
    if (cs_angle > adap_pkg::ALPHA_MAX) alpha_c = adap_pkg::ALPHA_MAX;
    if (cs_angle < -adap_pkg::ALPHA_MAX) alpha_c = -adap_pkg::ALPHA_MAX;
    beta_c = cs_angle;
    if (cs_angle > adap_pkg::BETA_MAX) beta_c = adap_pkg::BETA_MAX;
    if (cs_angle < -adap_pkg::BETA_MAX) beta_c = -adap_pkg::BETA_MAX;
  end

  assign diff     = 17'(alpha_r) - 17'(ref_alpha_r);
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
  assign rate_mag = (quo_r > adap_pkg::RATE_MAX) ? adap_pkg::RATE_MAX : quo_r;
  assign rate_s   = neg_r ? -16'(rate_mag) : 16'(rate_mag);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_SQX;
      S_SQX:     state_nxt = S_SQY;
      S_SQY:     state_nxt = S_SQZ;
      S_SQZ:     state_nxt = S_SUM;
      S_SUM:     state_nxt = S_QLO;
      S_QLO:     state_nxt = S_QHI;
      S_QHI:     state_nxt = S_RT1;
      S_RT1:     if (sq_b_r == '0) state_nxt = S_RT1_END;
      S_RT1_END: state_nxt = S_RT2_LD;
      S_RT2_LD:  state_nxt = S_RT2;
      S_RT2:     if (sq_b_r == '0) state_nxt = S_AL_GO;
      S_AL_GO:   state_nxt = S_AL_WAIT;
      S_AL_WAIT: if (cs_done) state_nxt = S_DIV_LD;
      S_DIV_LD:  state_nxt = (h_r == '0) ? S_BE_GO : S_DIV;
      S_DIV:     if (dcnt_r == 6'd0) state_nxt = S_BE_GO;
      S_BE_GO:   state_nxt = S_BE_WAIT;
      S_BE_WAIT: if (cs_done) state_nxt = S_FINISH;
      S_FINISH:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ref_alpha_r <= '0;
      held_rate_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_FINISH) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          ax_r    <= 22'($signed(in_tdata[19:0]))   - 22'($signed(in_tdata[79:60]));
          ay_r    <= 22'($signed(in_tdata[39:20]))  - 22'($signed(in_tdata[99:80]));
          az_r    <= 22'($signed(in_tdata[59:40]))  - 22'($signed(in_tdata[119:100]));
          rho_r   <= in_tdata[134:120];
          h_r     <= in_tdata[150:135];
          store_r <= in_tlast;
        end
        S_SQX: sx_r <= prod[40:0];
        S_SQY: sy_r <= prod;
        S_SQZ: syz_r <= sy_r + prod;
        S_SUM: s_r <= 42'(sx_r) + syz_r;
        S_QLO: qlo_r <= prod[35:0];
        S_QHI: begin
          qbar_r <= (qsh > 27'hFFFFFF) ? 24'hFFFFFF : qsh[23:0];
          sq_v_r <= s_r;
          sq_r_r <= '0;
          sq_b_r <= 42'd1 << 40;
        end
        S_RT1, S_RT2: if (sq_b_r != '0) begin
          if (43'(sq_v_r) >= sq_t) begin
            sq_v_r <= 42'(43'(sq_v_r) - sq_t);
            sq_r_r <= (sq_r_r >> 1) + 43'(sq_b_r);
          end else begin
            sq_r_r <= sq_r_r >> 1;
          end
          sq_b_r <= sq_b_r >> 2;
        end else if (state_r == S_RT2) begin
          side_r <= sq_r_r[21:0];
        end
        S_RT1_END: spd_r <= (sq_r_r > 43'hFFFFF) ? 20'hFFFFF : sq_r_r[19:0];
        S_RT2_LD: begin
          // Below 1 m/s the sideslip divisor is chosen so that it and ax lie on the 1 m/s circle.
          sq_v_r <= (s_r >= 42'd65536) ? syz_r : 42'd65536 - 42'(sx_r);
          sq_r_r <= '0;
          sq_b_r <= 42'd1 << 40;
        end
        S_AL_WAIT: if (cs_done) alpha_r <= 16'(-alpha_c);
        S_DIV_LD: begin
          neg_r  <= diff[16];
          quo_r  <= {diff_abs[15:0], 17'd0};
          rem_r  <= '0;
          dcnt_r <= 6'd32;
        end
        S_DIV: begin
          if (dsh >= 17'(h_r)) begin
            rem_r <= 16'(dsh - 17'(h_r));
            quo_r <= {quo_r[31:0], 1'b1};
          end else begin
            rem_r <= dsh[15:0];
            quo_r <= {quo_r[31:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
        end
        S_BE_GO: begin
          if (h_r != '0) held_rate_r <= rate_s;
          if (store_r) ref_alpha_r <= alpha_r;
        end
        S_BE_WAIT: if (cs_done) beta_r <= 15'(beta_c);
        S_FINISH: if (!out_valid_r || out_tready) begin
          out_data_r[19:0]   <= spd_r;
          out_data_r[35:20]  <= alpha_r;
          out_data_r[51:36]  <= held_rate_r;
          out_data_r[66:52]  <= beta_r;
          out_data_r[90:67]  <= qbar_r;
          out_data_r[95:91]  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/adap_checker.sv =====
// Port-level checks for air_data_angles_and_pressure_top, bound to the top level.
// Depends only on the top level's ports.
module adap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result request dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result request valid right after reset");

  a_beta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[66:52]) <= 15'sd12868) &&
                   ($signed(out_tdata[66:52]) >= -15'sd12868))
    else $error("sideslip out of range");

  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[51:36]) <= 16'sd16384) &&
                   ($signed(out_tdata[51:36]) >= -16'sd16384))
    else $error("alpha rate out of range");

  a_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[19:0] == 20'd0) |->
      (out_tdata[35:20] == 16'd0) && (out_tdata[66:52] == 15'd0) &&
      (out_tdata[90:67] == 24'd0))
    else $error("nonzero angles or pressure with zero airspeed");

endmodule

bind air_data_angles_and_pressure_top adap_checker u_adap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for air_data_angles_and_pressure_top: directed rows, then random
// flight-like, raw and edge-case requests, each result checked against its typed value or an in-bench
// air-data predictor. Depends on rtl/adap_pkg.sv and rtl/air_data_angles_and_pressure_top.sv.
module tb_top;

  localparam int NUM_RANDOM  = 1850;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 200;
  localparam int ALPHA_LIM   = 25736;
  localparam int BETA_LIM    = 12868;
  localparam int RATE_LIM    = 16384;
  localparam int ATAN_LEN    = 24;

  localparam logic signed [19:0] V0    = 20'sd0;
  localparam logic signed [19:0] V_MAX = 20'sd524287;
  localparam logic signed [19:0] V_MIN = 20'sh80000;

  localparam longint ARCTAN_Q30 [ATAN_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic signed [19:0] vx, vy, vz;
    logic signed [19:0] wx, wy, wz;
    logic [14:0]        rho;
    logic [15:0]        dt;
    logic               eos;
  } flow_req_t;

  // Lowest field last, so the layout matches the result bus.
  typedef struct packed {
    logic [23:0]        qbar;
    logic signed [14:0] beta;
    logic signed [15:0] alpha_rate;
    logic signed [15:0] alpha;
    logic [19:0]        speed;
  } air_data_t;

  typedef struct packed {
    flow_req_t stim;
    logic      typed;
    air_data_t want;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [151:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;

  air_data_t pending_air_data[$];
  logic signed [15:0] alpha_ref;
  logic signed [15:0] rate_hold;
  int errors;
  int n_sent;
  int n_checked;
  int idle_cycles;
  int rx_mode;
  int rx_stall;
  int rx_phase;

  air_data_angles_and_pressure_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC atan2 in Q13, clamped to +-lim.
  function automatic longint cordic_angle(longint yv, longint xv, longint lim);
    longint x, y, z, t, q, dx, dy;
    if (xv == 0 && yv == 0) return 0;
    x = xv * 16777216;
    y = yv * 16777216;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN_Q30;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN_Q30;
      end
    end
    for (int i = 0; i < adap_pkg::CORDIC_STEPS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end
    end
    q = (z + 65536) >>> 17;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  // Works out one result and advances the alpha reference and held rate.
  function automatic air_data_t predict_air_data(flow_req_t r);
    air_data_t res;
    longint ax, ay, az, alpha, rate, side;
    longint unsigned sx, syz, ssum, spd, qb;
    ax = longint'(r.vx) - longint'(r.wx);
    ay = longint'(r.vy) - longint'(r.wy);
    az = longint'(r.vz) - longint'(r.wz);
    sx = ax * ax;
    syz = ay * ay + az * az;
    ssum = sx + syz;
    spd = root_floor(ssum);
    if (spd > 64'hFFFFF) spd = 64'hFFFFF;
    alpha = -cordic_angle(az, ay, ALPHA_LIM);
    if (r.dt != 0) rate = (alpha - longint'(alpha_ref)) * 131072 / longint'(r.dt);
    else rate = longint'(rate_hold);
    if (rate > RATE_LIM) rate = RATE_LIM;
    if (rate < -RATE_LIM) rate = -RATE_LIM;
    rate_hold = rate[15:0];
    if (ssum >= 65536) side = longint'(root_floor(syz));
    else side = longint'(root_floor(65536 - sx));
    qb = (ssum * longint'(r.rho) + 64'h4000_0000) >> 31;
    if (qb > 64'hFFFFFF) qb = 64'hFFFFFF;
    if (r.eos) alpha_ref = alpha[15:0];
    res.speed = spd[19:0];
    res.alpha = alpha[15:0];
    res.alpha_rate = rate[15:0];
    res.beta = 15'(cordic_angle(ax, side, BETA_LIM));
    res.qbar = qb[23:0];
    return res;
  endfunction

  // Presents one request and holds it until taken; valid stays high afterwards.
  task automatic send_request(flow_req_t r, logic typed, air_data_t want);
    air_data_t guess;
    in_tdata  <= {1'b0, r.dt, r.rho, r.wz, r.wy, r.wx, r.vz, r.vy, r.vx};
    in_tlast  <= r.eos;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    guess = predict_air_data(r);
    pending_air_data.insert(pending_air_data.size(), typed ? want : guess);
    n_sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [19:0] rand_s(int mag);
    int v;
    v = int'($urandom_range(0, 2 * mag)) - mag;
    return v[19:0];
  endfunction

  function automatic flow_req_t random_request();
    flow_req_t r;
    int kind;
    kind = int'($urandom_range(0, 9));
    r = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case (kind)
      0, 1, 2: begin
      end
      3, 4, 5: begin
        r.vy = 20'($urandom_range(5000, 80000));
        r.vx = rand_s(20000);
        r.vz = rand_s(20000);
        r.wx = rand_s(3000);
        r.wy = rand_s(3000);
        r.wz = rand_s(3000);
        r.rho = 15'($urandom_range(8000, 20000));
        r.dt = 16'($urandom_range(100, 2000));
        r.eos = ($urandom_range(0, 3) != 0);
      end
      6: begin
        // Airflow around 1 m/s, where the sideslip falls back to the unit circle.
        r.wx = rand_s(400000);
        r.wy = rand_s(400000);
        r.wz = rand_s(400000);
        r.vx = r.wx + rand_s(300);
        r.vy = r.wy + rand_s(300);
        r.vz = r.wz + rand_s(300);
      end
      7: begin
        r.dt = 16'd0;
      end
      8: begin
        r.wx = r.vx;
        r.wy = r.vy;
        r.wz = r.vz;
      end
      default: begin
        r.vx = r.wx;
        r.vz = r.wz;
        r.vy = r.wy - 20'($urandom_range(1, 200000));
      end
    endcase
    return r;
  endfunction

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    air_data_t got, exp_r;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[90:0];
        if (pending_air_data.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = pending_air_data.pop_front();
          n_checked++;
          if (got.speed !== exp_r.speed) begin
            $display("%0t: airspeed exp %0d got %0d", $time, exp_r.speed, got.speed);
            errors++;
          end
          if (got.alpha !== exp_r.alpha) begin
            $display("%0t: alpha exp %0d got %0d", $time, exp_r.alpha, got.alpha);
            errors++;
          end
          if (got.alpha_rate !== exp_r.alpha_rate) begin
            $display("%0t: alpha rate exp %0d got %0d", $time, exp_r.alpha_rate,
                     got.alpha_rate);
            errors++;
          end
          if (got.beta !== exp_r.beta) begin
            $display("%0t: sideslip exp %0d got %0d", $time, exp_r.beta, got.beta);
            errors++;
          end
          if (got.qbar !== exp_r.qbar) begin
            $display("%0t: pressure exp %0d got %0d", $time, exp_r.qbar, got.qbar);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: free-running, coin-flip and long-stall phases, picked at random.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 300 == 0) rx_mode <= $urandom_range(0, 2);
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_stall <= $urandom_range(1, 40);
        end
      endcase
    end
  end

  dir_row_t directed_rows[13];

  initial begin
    air_data_t zero_res;
    flow_req_t req;
    int burst;
    zero_res = '0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    alpha_ref = '0;
    rate_hold = '0;
    rx_mode = 0;
    rx_stall = 0;
    rx_phase = 0;
    idle_cycles = 0;
    out_tready = 1'b1;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    rst_n = 1'b0;

    // Zero airflow right after reset gives an all-zero result.
    directed_rows[0]  = '{'{V0, V0, V0, V0, V0, V0, 15'd0, 16'd1, 1'b0}, 1'b1, zero_res};
    directed_rows[1]  = '{'{V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN,
                            15'd32767, 16'd65535, 1'b1}, 1'b0, zero_res};
    directed_rows[2]  = '{'{V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX,
                            15'd32767, 16'd1, 1'b0}, 1'b0, zero_res};
    directed_rows[3]  = '{'{V0, -20'sd1000, V0, V0, V0, V0, 15'd16384, 16'd0, 1'b1},
                          1'b0, zero_res};
    directed_rows[4]  = '{'{V0, V0, 20'sd5000, V0, V0, V0, 15'd16384, 16'd1, 1'b0},
                          1'b0, zero_res};
    directed_rows[5]  = '{'{V0, V0, -20'sd5000, V0, V0, V0, 15'd16384, 16'd1, 1'b1},
                          1'b0, zero_res};
    directed_rows[6]  = '{'{20'sd100, 20'sd50, V0, V0, V0, V0, 15'd100, 16'd100, 1'b0},
                          1'b0, zero_res};
    directed_rows[7]  = '{'{20'sd256, V0, V0, V0, V0, V0, 15'd16384, 16'd100, 1'b0},
                          1'b0, zero_res};
    directed_rows[8]  = '{'{20'sd255, V0, V0, V0, V0, V0, 15'd16384, 16'd100, 1'b0},
                          1'b0, zero_res};
    directed_rows[9]  = '{'{-20'sd200, 20'sd10, V0, V0, V0, V0, 15'd16384, 16'd100, 1'b0},
                          1'b0, zero_res};
    directed_rows[10] = '{'{V0, 20'sd30000, 20'sd3000, 20'sd2000, V0, V0,
                            15'd20000, 16'd655, 1'b1}, 1'b0, zero_res};
    directed_rows[11] = '{'{V0, 20'sd30000, 20'sd3000, 20'sd2000, V0, V0,
                            15'd20000, 16'd0, 1'b0}, 1'b0, zero_res};
    directed_rows[12] = '{'{V0, -20'sd30000, -20'sd10, V0, V0, V0,
                            15'd20000, 16'd300, 1'b1}, 1'b0, zero_res};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
      if ($urandom_range(0, 1) == 0) pause_sender($urandom_range(1, 20));
    end

    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        while (pending_air_data.size() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        pause_sender($urandom_range(1, 30));
        burst = $urandom_range(1, 25);
      end
      req = random_request();
      send_request(req, 1'b0, zero_res);
      burst--;
    end
    in_tvalid <= 1'b0;

    while (pending_air_data.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests (13 directed, rest random), checked %0d results.",
             n_sent, n_checked);
    if (errors == 0 && pending_air_data.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_air_data.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
